/* rtl/psdm_pkg.sv */
// ----------------------------------------------------------------------------
// psdm_pkg
// Shared widths, state encoding and cell control bundle for the pairwise
// squared distance matrix block.
// ----------------------------------------------------------------------------
package psdm_pkg;

    localparam int FEAT_W = 16;
    localparam int DIFF_W = FEAT_W + 1;
    localparam int PROD_W = 32;
    localparam int DIST_W = 35;
    localparam int PT_W   = 3;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_CALC,
        ST_DUMP
    } t_state;

    typedef struct packed {
        logic load;
        logic rotate;
        logic acc_en;
        logic acc_first;
        logic capture;
        logic res_shift;
    } t_cell_ctl;

endpackage

/* rtl/psdm_in_if.sv */
// ----------------------------------------------------------------------------
// psdm_in_if
// Feature input channel: one signed feature value per item.
// ----------------------------------------------------------------------------
interface psdm_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [psdm_pkg::FEAT_W-1:0] feature_value;

    modport source (output valid, output feature_value, input ready);
    modport sink   (input valid, input feature_value, output ready);
endinterface

/* rtl/psdm_out_if.sv */
// ----------------------------------------------------------------------------
// psdm_out_if
// Distance result channel: one matrix entry per item with its indices.
// ----------------------------------------------------------------------------
interface psdm_out_if;
    logic                         valid;
    logic                         ready;
    logic [psdm_pkg::DIST_W-1:0]  sq_distance;
    logic [psdm_pkg::PT_W-1:0]    row_point;
    logic [psdm_pkg::PT_W-1:0]    col_point;
    logic                         last_result;

    modport source (output valid, output sq_distance, output row_point,
                    output col_point, output last_result, input ready);
    modport sink   (input valid, input sq_distance, input row_point,
                    input col_point, input last_result, output ready);
endinterface

/* rtl/psdm_cell.sv */
// ----------------------------------------------------------------------------
// psdm_cell
// One point of the chain: holds its features in a rotating shift line,
// squares the difference to the broadcast row feature and accumulates it,
// and passes features and results on to its neighbor.
// ----------------------------------------------------------------------------
module psdm_cell #(
    parameter int NUM_FEATURES = 8
) (
    input  logic                                i_clk,
    input  psdm_pkg::t_cell_ctl                 i_ctl,
    input  logic signed [psdm_pkg::FEAT_W-1:0]  i_shift_in,
    input  logic signed [psdm_pkg::FEAT_W-1:0]  i_row_feat,
    input  logic [psdm_pkg::DIST_W-1:0]         i_res_in,
    output logic signed [psdm_pkg::FEAT_W-1:0]  o_head,
    output logic [psdm_pkg::DIST_W-1:0]         o_res
);
    import psdm_pkg::*;

    logic signed [FEAT_W-1:0]   r_feat [NUM_FEATURES];
    logic [PROD_W-1:0]          r_prod;
    logic [DIST_W-1:0]          r_acc;
    logic [DIST_W-1:0]          r_res;
    logic signed [DIFF_W-1:0]   l_diff;
    logic signed [2*DIFF_W-1:0] l_sq;

    assign o_head = r_feat[NUM_FEATURES-1];
    assign o_res  = r_res;
    assign l_diff = DIFF_W'(i_row_feat) - DIFF_W'(r_feat[NUM_FEATURES-1]);
    assign l_sq   = l_diff * l_diff;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_feat[0] <= i_shift_in;
        end else if (i_ctl.rotate) begin
            r_feat[0] <= r_feat[NUM_FEATURES-1];
        end
        for (int i = 1; i < NUM_FEATURES; i++) begin
            if (i_ctl.load || i_ctl.rotate) begin
                r_feat[i] <= r_feat[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rotate) begin
            r_prod <= l_sq[PROD_W-1:0];
        end
        if (i_ctl.acc_en) begin
            r_acc <= (i_ctl.acc_first ? '0 : r_acc) + DIST_W'(r_prod);
        end
        if (i_ctl.capture) begin
            r_res <= r_acc;
        end else if (i_ctl.res_shift) begin
            r_res <= i_res_in;
        end
    end

endmodule

/* rtl/pairwise_squared_distance_matrix_top.sv */
// ----------------------------------------------------------------------------
// pairwise_squared_distance_matrix_top
// Loads a set of points one feature per item and emits the full matrix of
// squared Euclidean distances in row-major order.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake      Payload
// i_feat    in   valid/ready    feature_value (16, signed)
// o_dist    out  valid/ready    sq_distance (35), row_point (3), col_point (3),
//                               last_result (1)
//
// Loading accepts one feature item per cycle. Each matrix row is then
// computed in the cell chain, whose cells have one multiply-accumulate
// each, and emitted from the last cell one entry at a time.
// Reset is synchronous and clears only control state.
// Input is not taken while a matrix is computed or emitted; output stalls
// hold the current result and the whole chain.
// ----------------------------------------------------------------------------
module pairwise_squared_distance_matrix_top #(
    parameter int NUM_POINTS   = 8,
    parameter int NUM_FEATURES = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    psdm_in_if.sink    i_feat,
    psdm_out_if.source o_dist
);
    import psdm_pkg::*;

    localparam int SET_SIZE = NUM_POINTS * NUM_FEATURES;
    localparam int CNT_W    = $clog2(SET_SIZE);
    localparam int PIDX_W   = $clog2(NUM_POINTS);
    localparam int PH_W     = $clog2(NUM_FEATURES + 2);

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [PIDX_W-1:0]   r_row, n_row;
    logic [PIDX_W-1:0]   r_col, n_col;
    logic [PH_W-1:0]     r_ph, n_ph;
    t_cell_ctl           l_ctl;

    logic signed [FEAT_W-1:0] l_heads [NUM_POINTS];
    logic [DIST_W-1:0]        l_res   [NUM_POINTS];
    logic signed [FEAT_W-1:0] l_row_feat;
    logic                     l_out_acc;

    assign l_row_feat = l_heads[PIDX_W'(NUM_POINTS - 1) - r_row];
    assign l_out_acc  = o_dist.valid && o_dist.ready;

    for (genvar k = 0; k < NUM_POINTS; k++) begin : g_cell
        psdm_cell #(
            .NUM_FEATURES(NUM_FEATURES)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (l_ctl),
            .i_shift_in ((k == 0) ? i_feat.feature_value : l_heads[(k == 0) ? 0 : k - 1]),
            .i_row_feat (l_row_feat),
            .i_res_in   ((k == 0) ? '0 : l_res[(k == 0) ? 0 : k - 1]),
            .o_head     (l_heads[k]),
            .o_res      (l_res[k])
        );
    end

    assign o_dist.sq_distance = l_res[NUM_POINTS-1];
    assign o_dist.row_point   = PT_W'(r_row);
    assign o_dist.col_point   = PT_W'(r_col);
    assign o_dist.last_result = (r_row == PIDX_W'(NUM_POINTS - 1)) &&
                                (r_col == PIDX_W'(NUM_POINTS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt   <= '0;
            r_row   <= '0;
            r_col   <= '0;
            r_ph    <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_row   <= n_row;
            r_col   <= n_col;
            r_ph    <= n_ph;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        n_row         = r_row;
        n_col         = r_col;
        n_ph          = r_ph;
        l_ctl         = '0;
        i_feat.ready  = 1'b0;
        o_dist.valid  = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                i_feat.ready = 1'b1;
                l_ctl.load   = i_feat.valid;
                if (i_feat.valid) begin
                    if (r_cnt == CNT_W'(SET_SIZE - 1)) begin
                        n_cnt   = '0;
                        n_row   = '0;
                        n_ph    = '0;
                        n_state = ST_CALC;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            ST_CALC: begin
                l_ctl.rotate    = (r_ph < PH_W'(NUM_FEATURES));
                l_ctl.acc_en    = (r_ph != '0) && (r_ph <= PH_W'(NUM_FEATURES));
                l_ctl.acc_first = (r_ph == PH_W'(1));
                l_ctl.capture   = (r_ph == PH_W'(NUM_FEATURES + 1));
                if (l_ctl.capture) begin
                    n_col   = '0;
                    n_state = ST_DUMP;
                end else begin
                    n_ph = r_ph + 1'b1;
                end
            end
            ST_DUMP: begin
                o_dist.valid    = 1'b1;
                l_ctl.res_shift = o_dist.ready;
                if (o_dist.ready) begin
                    if (r_col == PIDX_W'(NUM_POINTS - 1)) begin
                        n_col = '0;
                        if (r_row == PIDX_W'(NUM_POINTS - 1)) begin
                            n_state = ST_LOAD;
                        end else begin
                            n_row   = r_row + 1'b1;
                            n_ph    = '0;
                            n_state = ST_CALC;
                        end
                    end else begin
                        n_col = r_col + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_feat.ready && o_dist.valid))
        else $error("input taken while results are pending");

    a_end_of_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (l_out_acc && o_dist.last_result) |=> (r_state == ST_LOAD && r_cnt == '0))
        else $error("set did not restart after the final result");

    a_row_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CALC && r_ph == PH_W'(NUM_FEATURES + 1))
        |=> (o_dist.valid && o_dist.col_point == '0))
        else $error("row output did not start at column zero");
`endif

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pairwise squared distance matrix testbench
// Sends sets of eight points with eight signed features each through the
// feature channel. It holds its own copy of the point set and works out the
// full distance matrix for every completed set. Each emitted matrix entry is
// checked against the oldest expected one. Both channels idle at random, and
// one long result stall backs the block up into its input.
// ----------------------------------------------------------------------------
module testbench;
    import psdm_pkg::*;

    localparam int NUM_POINTS   = 8;
    localparam int NUM_FEATURES = 8;
    localparam int SET_SIZE     = NUM_POINTS * NUM_FEATURES;
    localparam int HOLD_CYCLES  = 500;
    localparam int DRAIN_CYCLES = 2 * NUM_POINTS * (2 * NUM_FEATURES + NUM_POINTS + 2);
    localparam int RANDOM_SETS  = 1;

    localparam logic signed [FEAT_W-1:0] FEAT_MIN = 16'h8000;
    localparam logic signed [FEAT_W-1:0] FEAT_MAX = 16'h7FFF;

    typedef struct packed {
        logic [DIST_W-1:0] sq_distance;
        logic [PT_W-1:0]   row_point;
        logic [PT_W-1:0]   col_point;
        logic              last_result;
    } t_dist_entry;

    logic i_clk = 1'b0;
    logic i_rst_n;

    psdm_in_if  feat_if();
    psdm_out_if dist_if();

    pairwise_squared_distance_matrix_top #(
        .NUM_POINTS  (NUM_POINTS),
        .NUM_FEATURES(NUM_FEATURES)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_feat (feat_if.sink),
        .o_dist (dist_if.source)
    );

    logic signed [FEAT_W-1:0] point_feats [SET_SIZE];
    int          feats_loaded;
    t_dist_entry expected_entries [$];

    int error_count;
    int items_sent;
    int sets_loaded;
    int entries_checked;
    bit steady_flow;
    bit hold_toggle;
    bit hold_seen;
    int hold_left;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [DIST_W-1:0] squared_distance(int a, int b);
        logic [DIST_W-1:0]        acc;
        logic signed [DIFF_W-1:0] diff;
        longint                   prod;
        acc = '0;
        for (int f = 0; f < NUM_FEATURES; f++) begin
            diff = DIFF_W'(point_feats[a * NUM_FEATURES + f])
                 - DIFF_W'(point_feats[b * NUM_FEATURES + f]);
            prod = longint'(diff) * longint'(diff);
            acc  = acc + DIST_W'(prod);
        end
        return acc;
    endfunction

    function automatic void push_distance_matrix();
        t_dist_entry entry;
        for (int r = 0; r < NUM_POINTS; r++) begin
            for (int c = 0; c < NUM_POINTS; c++) begin
                entry.sq_distance = squared_distance(r, c);
                entry.row_point   = PT_W'(r);
                entry.col_point   = PT_W'(c);
                entry.last_result = (r == NUM_POINTS - 1) && (c == NUM_POINTS - 1);
                expected_entries.push_back(entry);
            end
        end
    endfunction

    // Every accepted feature goes into the point set; a full set yields a matrix.
    always @(posedge i_clk) begin
        if (i_rst_n && feat_if.valid && feat_if.ready) begin
            point_feats[feats_loaded] = feat_if.feature_value;
            feats_loaded++;
            if (feats_loaded == SET_SIZE) begin
                push_distance_matrix();
                feats_loaded = 0;
                sets_loaded++;
            end
        end
    end

    always @(posedge i_clk) begin
        t_dist_entry want;
        if (i_rst_n && dist_if.valid && dist_if.ready) begin
            if (expected_entries.size() == 0) begin
                $error("Unexpected distance entry: row %0d col %0d value %0d",
                       dist_if.row_point, dist_if.col_point, dist_if.sq_distance);
                error_count++;
            end else begin
                want = expected_entries.pop_front();
                entries_checked++;
                if (dist_if.sq_distance !== want.sq_distance) begin
                    $error("sq_distance: expected %0d, actual %0d",
                           want.sq_distance, dist_if.sq_distance);
                    error_count++;
                end
                if (dist_if.row_point !== want.row_point) begin
                    $error("row_point: expected %0d, actual %0d",
                           want.row_point, dist_if.row_point);
                    error_count++;
                end
                if (dist_if.col_point !== want.col_point) begin
                    $error("col_point: expected %0d, actual %0d",
                           want.col_point, dist_if.col_point);
                    error_count++;
                end
                if (dist_if.last_result !== want.last_result) begin
                    $error("last_result: expected %0d, actual %0d",
                           want.last_result, dist_if.last_result);
                    error_count++;
                end
            end
        end
    end

    // Result side: random stalls, plus one long hold-off when requested.
    initial begin
        dist_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_toggle != hold_seen) begin
                hold_seen = hold_toggle;
                hold_left = HOLD_CYCLES;
            end
            if (!i_rst_n || hold_left > 0) begin
                if (hold_left > 0) begin
                    hold_left--;
                end
                dist_if.ready <= 1'b0;
            end else if (steady_flow) begin
                dist_if.ready <= 1'b1;
            end else begin
                dist_if.ready <= ($urandom_range(99) >= 25);
            end
        end
    end

    task automatic send_feature(input logic signed [FEAT_W-1:0] value);
        while (!steady_flow && $urandom_range(99) < 25) begin
            feat_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        feat_if.valid         <= 1'b1;
        feat_if.feature_value <= value;
        @(posedge i_clk);
        while (!feat_if.ready) begin
            @(posedge i_clk);
        end
        items_sent++;
    endtask

    function automatic logic signed [FEAT_W-1:0] random_feature();
        case ($urandom_range(9))
            0:       return FEAT_MIN;
            1:       return FEAT_MAX;
            2, 3:    return FEAT_W'($signed($urandom_range(16)) - 8);
            default: return FEAT_W'($urandom);
        endcase
    endfunction

    task automatic send_random_set();
        for (int i = 0; i < SET_SIZE; i++) begin
            send_feature(random_feature());
        end
    endtask

    // Points at opposite corners give the largest possible distance, which the result still holds.
    task automatic test_extreme_points();
        for (int p = 0; p < NUM_POINTS; p++) begin
            for (int f = 0; f < NUM_FEATURES; f++) begin
                if (p == NUM_POINTS - 1) begin
                    send_feature((f % 2) ? -16'sd1 : 16'sd0);
                end else if (p == NUM_POINTS - 2) begin
                    send_feature((f % 2) ? FEAT_MIN : FEAT_MAX);
                end else begin
                    send_feature((p % 2) ? FEAT_MAX : FEAT_MIN);
                end
            end
        end
    endtask

    // Identical points make every entry zero, and the new set overwrites the last.
    task automatic test_identical_points();
        logic signed [FEAT_W-1:0] shared [NUM_FEATURES];
        for (int f = 0; f < NUM_FEATURES; f++) begin
            shared[f] = random_feature();
        end
        for (int p = 0; p < NUM_POINTS; p++) begin
            for (int f = 0; f < NUM_FEATURES; f++) begin
                send_feature(shared[f]);
            end
        end
    endtask

    // The results are held off while the next set keeps being offered.
    task automatic test_result_backpressure();
        steady_flow = 1'b1;
        hold_toggle = ~hold_toggle;
        send_random_set();
        send_random_set();
        steady_flow = 1'b0;
    endtask

    task automatic test_random_sets();
        for (int s = 0; s < RANDOM_SETS; s++) begin
            send_random_set();
        end
    endtask

    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        i_rst_n               <= 1'b0;
        feat_if.valid         <= 1'b0;
        feat_if.feature_value <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extreme_points();
        test_identical_points();
        test_result_backpressure();
        test_random_sets();

        feat_if.valid <= 1'b0;
        while (expected_entries.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Loaded %0d point sets from %0d feature items.", sets_loaded, items_sent);
        $display("Checked %0d matrix entries, extremes and a long result stall included.",
                 entries_checked);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

/* sim.f */
rtl/psdm_pkg.sv
rtl/psdm_in_if.sv
rtl/psdm_out_if.sv
rtl/psdm_cell.sv
rtl/pairwise_squared_distance_matrix_top.sv
test/testbench.sv
